### hdl/lesb_pkg.sv
// Shared types and constants of the line-editing serial buffer.
// Holds the item layouts, the character codes and the controller/datapath links.
// Depends on nothing; lesb_dp, lesb_ctrl and the top level import it.
package lesb_pkg;

    // Default depth of the receive and transmit rings.
    localparam int DEFAULT_RING_DEPTH = 128;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_IRQ   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Character codes used by the line editor.
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Payload of one input beat.
    typedef struct packed {
        logic [1:0] operation;
        logic       rx_ready;
        logic       tx_done;
        logic [7:0] data_char;
    } in_item_t;

    // Payload of one result beat.
    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_char;
        logic       tx_start;
        logic [7:0] tx_char;
        logic       write_refused;
        logic       read_conflict;
    } out_item_t;

    // Which echo character a follow-up push step writes.
    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_SPACE,
        PUSH_BS,
        PUSH_LF
    } push_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      event_step;
        push_sel_t push;
        logic      serve;
        logic      capture;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic erase_ok;
        logic line_ok;
        logic slot_free;
    } dp_stat_t;

endpackage

### hdl/lesb_stream_if.sv
// Valid/ready channel that carries one payload beat per handshake.
// The payload type is a parameter; the item types come from lesb_pkg.
// Depends on nothing else.
interface lesb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/lesb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for both character rings of the line-editing serial buffer.
// Depends on nothing.
module lesb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### hdl/lesb_dp.sv
// Datapath of the line-editing serial buffer: ring pointers, counts, flags,
// the two ring memories and the result register.
// Depends on lesb_pkg and lesb_ram.
module lesb_dp #(
    parameter int RING_DEPTH = lesb_pkg::DEFAULT_RING_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lesb_pkg::in_item_t  item,
    input  lesb_pkg::ctl_cmd_t  cmd,
    output lesb_pkg::dp_stat_t  stat,
    output lesb_pkg::out_item_t result_data,
    output logic                result_valid,
    input  logic                result_ready
);
    import lesb_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);
    localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(RING_DEPTH);

    // Ring position one step forward, wrapping at the ring depth.
    function automatic logic [PTR_W-1:0] pos_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + PTR_W'(1);
    endfunction

    // Ring position one step back, wrapping at the ring depth.
    function automatic logic [PTR_W-1:0] pos_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_POS : p - PTR_W'(1);
    endfunction

    in_item_t         item_reg;
    logic [PTR_W-1:0] rx_head_reg, rx_head_next;
    logic [PTR_W-1:0] rx_tail_reg, rx_tail_next;
    logic [CNT_W-1:0] ready_cnt_reg, ready_cnt_next;
    logic [CNT_W-1:0] edit_cnt_reg, edit_cnt_next;
    logic [PTR_W-1:0] tx_head_reg, tx_head_next;
    logic [PTR_W-1:0] tx_tail_reg, tx_tail_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_next;
    logic             waiting_reg, waiting_next;
    logic             tx_idle_reg, tx_idle_next;
    logic             refused_reg, refused_next;
    logic             conflict_reg, conflict_next;
    logic             rv_pend_reg, rv_pend_next;
    logic             ts_pend_reg, ts_pend_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg;

    logic [7:0]       ch;
    logic             irq_rx;
    logic             is_erase_ch;
    logic             is_nl_ch;
    logic             is_print_ch;
    logic [SUM_W-1:0] line_sum;
    logic             rx_room;
    logic             erase_ok;
    logic             line_ok;
    logic             print_ok;
    logic             op_write;
    logic             tx_room;
    logic             ev_push;
    logic [7:0]       ev_push_char;
    logic             push_en;
    logic [7:0]       push_char;
    logic             rx_wr_en;
    logic [7:0]       rx_wr_data;
    logic             serve_rx;
    logic             serve_tx;
    logic [7:0]       rx_rd_data;
    logic [7:0]       tx_rd_data;

    // Classify the held beat against the ring state before this step.
    assign ch          = item_reg.data_char;
    assign irq_rx      = (item_reg.operation == OP_IRQ) && item_reg.rx_ready;
    assign is_erase_ch = (ch == CH_BS) || (ch == CH_DEL);
    assign is_nl_ch    = (ch == CH_CR) || (ch == CH_LF);
    assign is_print_ch = (ch >= CH_SPACE) && (ch < CH_DEL);
    assign line_sum    = {1'b0, ready_cnt_reg} + {1'b0, edit_cnt_reg};
    assign rx_room     = line_sum < FULL_SUM;
    assign erase_ok    = irq_rx && is_erase_ch && (edit_cnt_reg != '0);
    assign line_ok     = irq_rx && is_nl_ch && rx_room;
    assign print_ok    = irq_rx && is_print_ch && rx_room;
    assign op_write    = item_reg.operation == OP_WRITE;
    assign tx_room     = tx_cnt_reg < FULL_CNT;

    // Character pushed into the transmit ring on the event step.
    assign ev_push = erase_ok || line_ok || print_ok || op_write;
    always_comb
    begin
        if (erase_ok)
        begin
            ev_push_char = CH_BS;
        end
        else if (line_ok)
        begin
            ev_push_char = CH_CR;
        end
        else
        begin
            ev_push_char = ch;
        end
    end

    // Transmit ring write: the event step or one of the follow-up echo steps.
    always_comb
    begin
        push_en   = 1'b0;
        push_char = ev_push_char;
        case (cmd.push)
            PUSH_SPACE:
            begin
                push_en   = tx_room;
                push_char = CH_SPACE;
            end
            PUSH_BS:
            begin
                push_en   = tx_room;
                push_char = CH_BS;
            end
            PUSH_LF:
            begin
                push_en   = tx_room;
                push_char = CH_LF;
            end
            default:
            begin
                push_en = cmd.event_step && ev_push && tx_room;
            end
        endcase
    end

    // Receive ring write on the event step.
    assign rx_wr_en   = cmd.event_step && (line_ok || print_ok);
    assign rx_wr_data = line_ok ? CH_LF : ch;

    // Reader and transmitter service.
    assign serve_rx = cmd.serve && waiting_reg && (ready_cnt_reg != '0);
    assign serve_tx = cmd.serve && tx_idle_reg && (tx_cnt_reg != '0);

    // Next state of pointers, counts and flags.
    always_comb
    begin
        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        ready_cnt_next = ready_cnt_reg;
        edit_cnt_next  = edit_cnt_reg;
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        tx_cnt_next    = tx_cnt_reg;
        waiting_next   = waiting_reg;
        tx_idle_next   = tx_idle_reg;
        refused_next   = refused_reg;
        conflict_next  = conflict_reg;
        rv_pend_next   = rv_pend_reg;
        ts_pend_next   = ts_pend_reg;

        if (cmd.load)
        begin
            refused_next  = 1'b0;
            conflict_next = 1'b0;
            rv_pend_next  = 1'b0;
            ts_pend_next  = 1'b0;
        end

        if (cmd.event_step)
        begin
            if (erase_ok)
            begin
                edit_cnt_next = edit_cnt_reg - CNT_W'(1);
                rx_head_next  = pos_dec(rx_head_reg);
            end
            if (line_ok)
            begin
                rx_head_next   = pos_inc(rx_head_reg);
                ready_cnt_next = ready_cnt_reg + edit_cnt_reg + CNT_W'(1);
                edit_cnt_next  = '0;
            end
            if (print_ok)
            begin
                rx_head_next  = pos_inc(rx_head_reg);
                edit_cnt_next = edit_cnt_reg + CNT_W'(1);
            end
            if ((item_reg.operation == OP_IRQ) && item_reg.tx_done)
            begin
                tx_idle_next = 1'b1;
            end
            if (item_reg.operation == OP_READ)
            begin
                if (waiting_reg)
                begin
                    conflict_next = 1'b1;
                end
                else
                begin
                    waiting_next = 1'b1;
                end
            end
            if (op_write && !tx_room)
            begin
                refused_next = 1'b1;
            end
        end

        if (push_en)
        begin
            tx_head_next = pos_inc(tx_head_reg);
            tx_cnt_next  = tx_cnt_reg + CNT_W'(1);
        end

        if (serve_rx)
        begin
            rx_tail_next   = pos_inc(rx_tail_reg);
            ready_cnt_next = ready_cnt_reg - CNT_W'(1);
            waiting_next   = 1'b0;
            rv_pend_next   = 1'b1;
        end

        if (serve_tx)
        begin
            tx_tail_next = pos_inc(tx_tail_reg);
            tx_cnt_next  = tx_cnt_reg - CNT_W'(1);
            tx_idle_next = 1'b0;
            ts_pend_next = 1'b1;
        end
    end

    // Result slot: filled on capture, emptied when the beat is taken.
    always_comb
    begin
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            ready_cnt_reg <= '0;
            edit_cnt_reg  <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_cnt_reg    <= '0;
            waiting_reg   <= 1'b0;
            tx_idle_reg   <= 1'b1;
            refused_reg   <= 1'b0;
            conflict_reg  <= 1'b0;
            rv_pend_reg   <= 1'b0;
            ts_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            ready_cnt_reg <= ready_cnt_next;
            edit_cnt_reg  <= edit_cnt_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_cnt_reg    <= tx_cnt_next;
            waiting_reg   <= waiting_next;
            tx_idle_reg   <= tx_idle_next;
            refused_reg   <= refused_next;
            conflict_reg  <= conflict_next;
            rv_pend_reg   <= rv_pend_next;
            ts_pend_reg   <= ts_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the held input beat and the result beat.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.capture)
        begin
            out_reg.reply_valid   <= rv_pend_reg;
            out_reg.reply_char    <= rv_pend_reg ? rx_rd_data : 8'h00;
            out_reg.tx_start      <= ts_pend_reg;
            out_reg.tx_char       <= ts_pend_reg ? tx_rd_data : 8'h00;
            out_reg.write_refused <= refused_reg;
            out_reg.read_conflict <= conflict_reg;
        end
    end

    // Receive ring: written at the head, read at the tail.
    lesb_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_head_reg),
        .wr_data (rx_wr_data),
        .rd_en   (serve_rx),
        .rd_addr (rx_tail_reg),
        .rd_data (rx_rd_data)
    );

    // Transmit ring: written at the head, read at the tail.
    lesb_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (push_en),
        .wr_addr (tx_head_reg),
        .wr_data (push_char),
        .rd_en   (serve_tx),
        .rd_addr (tx_tail_reg),
        .rd_data (tx_rd_data)
    );

    assign stat.erase_ok  = erase_ok;
    assign stat.line_ok   = line_ok;
    assign stat.slot_free = !out_valid_reg || result_ready;
    assign result_data    = out_reg;
    assign result_valid   = out_valid_reg;
endmodule

### hdl/lesb_ctrl.sv
// Controller of the line-editing serial buffer: steps one beat through
// event handling, echo pushes, service and result capture.
// Depends on lesb_pkg.
module lesb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lesb_pkg::dp_stat_t stat,
    output lesb_pkg::ctl_cmd_t cmd
);
    import lesb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVENT,
        S_ERASE_SPACE,
        S_ERASE_BS,
        S_LINE_LF,
        S_SERVE,
        S_CAPTURE
    } state_t;

    state_t state_reg, state_next;

    // Commands and next state for each step.
    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.event_step = 1'b0;
        cmd.push       = PUSH_NONE;
        cmd.serve      = 1'b0;
        cmd.capture    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_EVENT;
                end
            end
            S_EVENT:
            begin
                cmd.event_step = 1'b1;
                if (stat.erase_ok)
                begin
                    state_next = S_ERASE_SPACE;
                end
                else if (stat.line_ok)
                begin
                    state_next = S_LINE_LF;
                end
                else
                begin
                    state_next = S_SERVE;
                end
            end
            S_ERASE_SPACE:
            begin
                cmd.push   = PUSH_SPACE;
                state_next = S_ERASE_BS;
            end
            S_ERASE_BS:
            begin
                cmd.push   = PUSH_BS;
                state_next = S_SERVE;
            end
            S_LINE_LF:
            begin
                cmd.push   = PUSH_LF;
                state_next = S_SERVE;
            end
            S_SERVE:
            begin
                if (stat.slot_free)
                begin
                    cmd.serve  = 1'b1;
                    state_next = S_CAPTURE;
                end
            end
            S_CAPTURE:
            begin
                cmd.capture = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule

### hdl/line_editing_serial_buffer.sv
// Line-editing serial buffer: a canonical line discipline with a receive ring
// and a transmit ring of RING_DEPTH characters each. Every input beat
// (interrupt event, read request or write) yields exactly one result beat.
// A beat passes through the event, service and capture steps before the next acceptance;
// a stored line end adds an LF push step and an erase that removes a character adds
// a space push and a backspace push step, since echo characters enter the transmit
// ring memory one per cycle through its single write port; a result still held on
// the output delays the next beat's service step. Rings need no clearing after reset.
// Depends on lesb_pkg, lesb_stream_if, lesb_ram, lesb_dp and lesb_ctrl.
module line_editing_serial_buffer #(
    parameter int RING_DEPTH = lesb_pkg::DEFAULT_RING_DEPTH
) (
    input logic          clk,
    input logic          rst_n,
    lesb_stream_if.sink   request,
    lesb_stream_if.source result
);
    import lesb_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Step sequencer.
    lesb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Rings, counters and result register.
    lesb_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (request.data),
        .cmd          (cmd),
        .stat         (stat),
        .result_data  (result.data),
        .result_valid (result.valid),
        .result_ready (result.ready)
    );

`ifndef NO_ASSERTIONS
    // At most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.event_step, cmd.push != PUSH_NONE, cmd.serve, cmd.capture}))
        else $error("controller issued more than one command");

    // A result is only captured into an output slot that is empty or whose beat is being taken.
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> stat.slot_free)
        else $error("result captured over a pending beat");

    // After a beat is accepted the block takes no further beat next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("second beat accepted while one is in work");

    // A write refusal and a read conflict never come from the same beat.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.data.write_refused && result.data.read_conflict))
        else $error("refusal and conflict flagged together");
`endif
endmodule
